// ===== rtl/core/tlvo_pkg.sv =====
// Package for the transport option segment size extractor.
// Shared types and fixed constants; no dependencies.
`default_nettype none

package tlvo_pkg;

  typedef enum logic [1:0] {
    ST_END   = 2'd0,
    ST_COUNT = 2'd1,
    ST_NONE  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_OPTION = 1'b1
  } cmd_t;

  localparam logic [7:0]  HDR_MASK   = 8'hF0;
  localparam logic [7:0]  HDR_DIV    = 8'd8;
  localparam logic [4:0]  HDR_BASE   = 5'h14;
  localparam logic [15:0] SIZE_RESET = 16'h218;

  localparam logic [7:0] KIND_END  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] LEN_MIN   = 8'd2;

endpackage

`default_nettype wire

// ===== rtl/core/tlvo_in_if.sv =====
// Input channel interface: valid/ready handshake with command and value.
// No dependencies.
`default_nettype none

interface tlvo_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlvo_out_if.sv =====
// Result channel interface: valid/ready handshake with size and status.
// No dependencies.
`default_nettype none

interface tlvo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] size_value;
  logic        size_found;
  logic [1:0]  status;

  modport source (output valid, output size_value, output size_found, output status,
                  input ready);
  modport sink   (input valid, input size_value, input size_found, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlv_option_mss_extractor.sv =====
// Top level: transport option walker reporting the segment size.
// Depends on tlvo_pkg, tlvo_in_if and tlvo_out_if.
`default_nettype none

// Takes one item per cycle: a start item with the header byte, then option
// bytes. State is updated in the cycle an item is accepted, and a result, if
// any, appears in the output register on the next cycle. in_ch.ready is low
// only while that register holds a result that the sink is not taking, so a
// steady stream runs at one item per clock. cfg_wdata written with cfg_we
// sets the default size, copied into the walk at each start item.

module tlv_option_mss_extractor
  import tlvo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  tlvo_in_if.sink          in_ch,
  tlvo_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_KIND    = 3'd1,
    PH_MSS_LEN = 3'd2,
    PH_MSS_LO  = 3'd3,
    PH_MSS_HI  = 3'd4,
    PH_OPT_LEN = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  skip_left_r, skip_left_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic        found_r, found_nxt;
  logic [15:0] default_size_r;

  logic        out_valid_r;
  logic [15:0] out_size_r;
  logic        out_found_r;
  status_t     out_status_r;

  logic        in_acc;
  logic        emit;
  status_t     emit_status;
  logic [4:0]  bl_dec;
  logic [7:0]  skip_dec;
  logic [4:0]  hdr_words;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign bl_dec      = bytes_left_r - 5'd1;
  assign skip_dec    = skip_left_r - 8'd1;
  assign hdr_words   = 5'((in_ch.value & HDR_MASK) / HDR_DIV);

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    skip_left_nxt  = skip_left_r;
    size_nxt       = size_r;
    low_hold_nxt   = low_hold_r;
    found_nxt      = found_r;
    emit           = 1'b0;
    emit_status    = ST_END;
    if (in_ch.command == CMD_START) begin
      size_nxt      = default_size_r;
      found_nxt     = 1'b0;
      low_hold_nxt  = '0;
      skip_left_nxt = '0;
      if (hdr_words <= HDR_BASE) begin
        bytes_left_nxt = '0;
        phase_nxt      = PH_IDLE;
        emit           = 1'b1;
        emit_status    = ST_NONE;
      end else begin
        bytes_left_nxt = hdr_words - HDR_BASE;
        phase_nxt      = PH_KIND;
      end
    end else begin
      if (phase_r != PH_IDLE) bytes_left_nxt = bl_dec;
      unique case (phase_r)
        PH_KIND: begin
          priority if (in_ch.value == KIND_END) begin
            emit        = 1'b1;
            emit_status = ST_END;
          end else if (in_ch.value == KIND_NOP) begin
            if (bl_dec == '0) begin
              emit        = 1'b1;
              emit_status = ST_COUNT;
            end
          end else if (in_ch.value == KIND_MSS) begin
            if (bl_dec < 5'd3) begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end else begin
              phase_nxt = PH_MSS_LEN;
            end
          end else begin
            if (bl_dec == '0) begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end else begin
              phase_nxt = PH_OPT_LEN;
            end
          end
        end
        PH_MSS_LEN: phase_nxt = PH_MSS_LO;
        PH_MSS_LO: begin
          low_hold_nxt = in_ch.value;
          phase_nxt    = PH_MSS_HI;
        end
        PH_MSS_HI: begin
          size_nxt  = {in_ch.value, low_hold_r};
          found_nxt = 1'b1;
          phase_nxt = PH_KIND;
          if (bl_dec == '0) begin
            emit        = 1'b1;
            emit_status = ST_COUNT;
          end
        end
        PH_OPT_LEN: begin
          if (in_ch.value < LEN_MIN || (in_ch.value - LEN_MIN) > {3'b000, bl_dec}) begin
            emit        = 1'b1;
            emit_status = ST_BAD;
          end else begin
            skip_left_nxt = in_ch.value - LEN_MIN;
            if (in_ch.value == LEN_MIN) begin
              phase_nxt = PH_KIND;
              if (bl_dec == '0) begin
                emit        = 1'b1;
                emit_status = ST_COUNT;
              end
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_left_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_KIND;
            if (bl_dec == '0) begin
              emit        = 1'b1;
              emit_status = ST_COUNT;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (emit) phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_size_r <= SIZE_RESET;
      phase_r        <= PH_IDLE;
      bytes_left_r   <= '0;
      skip_left_r    <= '0;
      size_r         <= SIZE_RESET;
      low_hold_r     <= '0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) default_size_r <= cfg_wdata;
      if (in_acc) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        skip_left_r  <= skip_left_nxt;
        size_r       <= size_nxt;
        low_hold_r   <= low_hold_nxt;
        found_r      <= found_nxt;
        out_valid_r  <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_size_r   <= size_nxt;
      out_found_r  <= found_nxt;
      out_status_r <= emit_status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.size_value = out_size_r;
  assign out_ch.size_found = out_found_r;
  assign out_ch.status     = out_status_r;

  a_short_hdr_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == CMD_START && in_ch.value[7:4] <= 4'd10
    |=> out_valid_r && out_status_r == ST_NONE)
    else $error("short header did not give a no-options result");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> phase_r == PH_IDLE)
    else $error("walk still active after a result");

  a_walk_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> bytes_left_r != 5'd0)
    else $error("walk active with no option bytes left");

endmodule

`default_nettype wire
